// ===== design/acbm_pkg.sv =====
// Shared types, codes and sizes for the Aho-Corasick byte matcher.
package acbm_pkg;

	localparam int MAX_STATES   = 128;
	localparam int MAX_PATTERNS = 16;
	localparam int ALPHABET     = 256;
	localparam int SW           = $clog2(MAX_STATES);
	localparam int CW           = $clog2(ALPHABET);
	localparam int GA_W         = SW + CW;
	localparam int WW           = $clog2(MAX_PATTERNS);
	localparam int NF_W         = SW + 1;

	typedef enum logic [2:0] {
		CMD_CLEAR   = 3'd0,
		CMD_PATTERN = 3'd1,
		CMD_END     = 3'd2,
		CMD_BUILD   = 3'd3,
		CMD_TEXT    = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_MATCH = 2'd0,
		KIND_BUILD = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_FULL      = 2'd1,
		ERR_PATTERNS  = 2'd2,
		ERR_NOT_BUILT = 2'd3
	} err_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] data_byte;
		logic       start_of_text;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  word_index;
		logic [31:0] end_position;
		logic [7:0]  state_count;
		logic [1:0]  error_code;
		logic        last;
	} result_t;

	typedef enum logic [4:0] {
		ST_RCLR,
		ST_IDLE,
		ST_PB,
		ST_EP,
		ST_B_GRD,
		ST_B_GCHK,
		ST_WALK,
		ST_WROOT,
		ST_WCHK,
		ST_WFL,
		ST_WDONE,
		ST_B_MT,
		ST_B_MW,
		ST_B_NEXTC,
		ST_B_POP,
		ST_B_PCHK,
		ST_B_FS,
		ST_T_MASK,
		ST_T_EMIT
	} state_t;

endpackage

// ===== design/aho_corasick_byte_matcher.sv =====
// Aho-Corasick byte matcher: trie load, link build and text scan over block memories.
//
// Commands are taken while busy is low. The state lives in four registered-read
// memories (goto rows, failure links, output masks, build queue), so every item
// is a short sequence of reads and write-backs: a pattern byte that allocates a
// state adds a clear of the new goto row, and clear rewrites the root row. A
// text byte adds a walk step per failure hop and, when every match is reported,
// a step per reported match. A build visits every (state, symbol) pair, with
// added steps per edge, per queued state and per failure hop. After reset the
// root row is cleared with busy high. Results appear one per cycle on result
// with strobe high, in the cycle after they are formed, and cannot be held off
// by the receiver.
module aho_corasick_byte_matcher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  acbm_pkg::in_item_t item,
	output logic              busy,
	output logic              strobe,
	output acbm_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import acbm_pkg::*;

	// Memories
	logic [SW-1:0] goto_mem [MAX_STATES*ALPHABET];
	logic [SW-1:0] fail_mem [MAX_STATES];
	logic [MAX_PATTERNS-1:0] mask_mem [MAX_STATES];
	logic [SW-1:0] queue_mem [MAX_STATES];

	logic [GA_W-1:0] g_ra, g_wa;
	logic [SW-1:0]   g_rd, g_wd;
	logic            g_we;
	logic [SW-1:0]   f_ra, f_wa, f_rd, f_wd;
	logic            f_we;
	logic [SW-1:0]   m_ra, m_wa;
	logic [MAX_PATTERNS-1:0] m_rd, m_wd;
	logic            m_we;
	logic [SW-1:0]   q_ra, q_wa, q_rd, q_wd;
	logic            q_we;

	state_t state_q, state_d;

	logic [NF_W-1:0] next_free_q;
	logic [WW:0]     pat_q;
	logic [SW-1:0]   ins_q, scan_q, x_q, t_q, f_q, fs_q, cur_q, row_q;
	logic [31:0]     pos_q, mpos_q;
	logic            built_q, first_q, fmo_q, txt_q;
	logic [CW-1:0]   c_q, cnt_q;
	logic [MAX_PATTERNS-1:0] mf_q, mk_q;
	logic [SW:0]     head_q, tail_q;

	logic            accept, emit;
	result_t         res_d;
	logic [CW-1:0]   sym;
	cmd_t            cmd;
	logic            pat_full;
	logic [WW-1:0]   low_idx, low_mk;
	logic [MAX_PATTERNS-1:0] mk_rest;

	// Find the lowest set bit of a word mask
	function automatic logic [WW-1:0] lowest(input logic [MAX_PATTERNS-1:0] m);
		logic [WW-1:0] r;
		r = '0;
		for (int i = MAX_PATTERNS - 1; i >= 0; i--) begin
			if (m[i]) r = WW'(i);
		end
		return r;
	endfunction

	assign sym      = item.data_byte[CW-1:0];
	assign cmd      = cmd_t'(item.command);
	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign pat_full = (pat_q >= (WW+1)'(MAX_PATTERNS));
	assign low_idx  = lowest(m_rd);
	assign low_mk   = lowest(mk_q);
	assign mk_rest  = mk_q & ~(MAX_PATTERNS'(1) << low_mk);

	// Memory ports
	always_ff @(posedge clk) begin
		if (g_we) goto_mem[g_wa] <= g_wd;
		g_rd <= goto_mem[g_ra];
		if (f_we) fail_mem[f_wa] <= f_wd;
		f_rd <= fail_mem[f_ra];
		if (m_we) mask_mem[m_wa] <= m_wd;
		m_rd <= mask_mem[m_ra];
		if (q_we) queue_mem[q_wa] <= q_wd;
		q_rd <= queue_mem[q_ra];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RCLR: if (cnt_q == CW'(ALPHABET - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_CLEAR:   state_d = ST_RCLR;
						CMD_PATTERN: if (!pat_full) state_d = ST_PB;
						CMD_END:     if (!pat_full) state_d = ST_EP;
						CMD_BUILD:   state_d = ST_B_GRD;
						CMD_TEXT:    if (built_q) state_d = ST_WALK;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_PB: begin
				if (g_rd == '0 && next_free_q < NF_W'(MAX_STATES)) state_d = ST_RCLR;
				else state_d = ST_IDLE;
			end
			ST_EP:      state_d = ST_IDLE;
			ST_B_GRD:   state_d = ST_B_GCHK;
			ST_B_GCHK: begin
				if (g_rd == '0) state_d = ST_B_NEXTC;
				else if (cur_q == '0) state_d = ST_WDONE;
				else state_d = ST_WALK;
			end
			ST_WALK:    state_d = (x_q == '0) ? ST_WROOT : ST_WCHK;
			ST_WROOT:   state_d = ST_WDONE;
			ST_WCHK:    state_d = (g_rd != '0) ? ST_WDONE : ST_WFL;
			ST_WFL:     state_d = ST_WALK;
			ST_WDONE:   state_d = txt_q ? ST_T_MASK : ST_B_MT;
			ST_B_MT:    state_d = ST_B_MW;
			ST_B_MW:    state_d = ST_B_NEXTC;
			ST_B_NEXTC: state_d = (c_q == CW'(ALPHABET - 1)) ? ST_B_POP : ST_B_GRD;
			ST_B_POP:   state_d = (head_q == tail_q) ? ST_IDLE : ST_B_PCHK;
			ST_B_PCHK:  state_d = ST_B_FS;
			ST_B_FS:    state_d = ST_B_GRD;
			ST_T_MASK: begin
				if (fmo_q || m_rd == '0) state_d = ST_IDLE;
				else state_d = ST_T_EMIT;
			end
			ST_T_EMIT:  if (mk_rest == '0) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Outputs: memory controls and result formation
	always_comb begin
		g_ra = {ins_q, sym};
		g_wa = {row_q, cnt_q};
		g_wd = '0;
		g_we = 1'b0;
		f_ra = x_q;
		f_wa = row_q;
		f_wd = '0;
		f_we = 1'b0;
		m_ra = ins_q;
		m_wa = row_q;
		m_wd = '0;
		m_we = 1'b0;
		q_ra = head_q[SW-1:0];
		q_wa = tail_q[SW-1:0];
		q_wd = t_q;
		q_we = 1'b0;
		emit = 1'b0;
		res_d = '0;
		unique case (state_q)
			ST_RCLR: begin
				g_we = 1'b1;
				f_we = (cnt_q == '0);
				m_we = (cnt_q == '0);
			end
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_PATTERN, CMD_END: begin
							if (pat_full) begin
								emit = 1'b1;
								res_d.kind = KIND_ERROR;
								res_d.error_code = ERR_PATTERNS;
								res_d.last = 1'b1;
							end
						end
						CMD_TEXT: begin
							if (!built_q) begin
								emit = 1'b1;
								res_d.kind = KIND_ERROR;
								res_d.error_code = ERR_NOT_BUILT;
								res_d.last = 1'b1;
							end
						end
						default: emit = 1'b0;
					endcase
				end
			end
			ST_PB: begin
				if (g_rd == '0) begin
					if (next_free_q >= NF_W'(MAX_STATES)) begin
						emit = 1'b1;
						res_d.kind = KIND_ERROR;
						res_d.error_code = ERR_FULL;
						res_d.last = 1'b1;
					end else begin
						g_we = 1'b1;
						g_wa = {ins_q, c_q};
						g_wd = next_free_q[SW-1:0];
					end
				end
			end
			ST_EP: begin
				m_we = 1'b1;
				m_wa = ins_q;
				m_wd = m_rd | (MAX_PATTERNS'(1) << pat_q[WW-1:0]);
			end
			ST_B_GRD: g_ra = {cur_q, c_q};
			ST_WALK:  g_ra = {x_q, c_q};
			ST_WCHK:  f_ra = x_q;
			ST_WDONE: begin
				m_ra = f_q;
				if (!txt_q) begin
					f_we = 1'b1;
					f_wa = t_q;
					f_wd = f_q;
				end
			end
			ST_B_MT:  m_ra = t_q;
			ST_B_MW: begin
				m_we = 1'b1;
				m_wa = t_q;
				m_wd = m_rd | mf_q;
				q_we = 1'b1;
			end
			ST_B_POP: begin
				if (head_q == tail_q) begin
					emit = 1'b1;
					res_d.kind = KIND_BUILD;
					res_d.state_count = 8'(next_free_q);
					res_d.last = 1'b1;
				end
			end
			ST_B_PCHK: f_ra = q_rd;
			ST_T_MASK: begin
				if (fmo_q && !first_q && m_rd != '0) begin
					emit = 1'b1;
					res_d.kind = KIND_MATCH;
					res_d.word_index = 4'(low_idx);
					res_d.end_position = mpos_q;
					res_d.last = 1'b1;
				end
			end
			ST_T_EMIT: begin
				emit = 1'b1;
				res_d.kind = KIND_MATCH;
				res_d.word_index = 4'(low_mk);
				res_d.end_position = mpos_q;
				res_d.last = (mk_rest == '0);
			end
			default: emit = 1'b0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RCLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= NF_W'(1);
			pat_q       <= '0;
			ins_q       <= '0;
			scan_q      <= '0;
			pos_q       <= '0;
			built_q     <= 1'b0;
			first_q     <= 1'b0;
			fmo_q       <= 1'b0;
			row_q       <= '0;
			cnt_q       <= '0;
			strobe      <= 1'b0;
			result      <= '0;
			x_q         <= '0;
			t_q         <= '0;
			f_q         <= '0;
			fs_q        <= '0;
			cur_q       <= '0;
			mpos_q      <= '0;
			txt_q       <= 1'b0;
			c_q         <= '0;
			mf_q        <= '0;
			mk_q        <= '0;
			head_q      <= '0;
			tail_q      <= '0;
		end else begin
			strobe <= emit;
			result <= res_d;
			if (cfg_valid) fmo_q <= cfg_data;
			unique case (state_q)
				ST_RCLR: cnt_q <= cnt_q + CW'(1);
				ST_IDLE: begin
					if (accept) begin
						c_q <= (cmd == CMD_BUILD) ? CW'(0) : sym;
						case (cmd)
							CMD_CLEAR: begin
								next_free_q <= NF_W'(1);
								pat_q   <= '0;
								ins_q   <= '0;
								scan_q  <= '0;
								pos_q   <= '0;
								built_q <= 1'b0;
								first_q <= 1'b0;
								row_q   <= '0;
								cnt_q   <= '0;
							end
							CMD_PATTERN: if (!pat_full) built_q <= 1'b0;
							CMD_BUILD: begin
								cur_q  <= '0;
								head_q <= '0;
								tail_q <= '0;
								txt_q  <= 1'b0;
							end
							CMD_TEXT: begin
								if (built_q) begin
									txt_q <= 1'b1;
									if (item.start_of_text) begin
										x_q     <= '0;
										mpos_q  <= '0;
										pos_q   <= 32'd1;
										first_q <= 1'b0;
									end else begin
										x_q    <= scan_q;
										mpos_q <= pos_q;
										pos_q  <= pos_q + 32'd1;
									end
								end
							end
							default: txt_q <= txt_q;
						endcase
					end
				end
				ST_PB: begin
					if (g_rd != '0) begin
						ins_q <= g_rd;
					end else if (next_free_q < NF_W'(MAX_STATES)) begin
						ins_q       <= next_free_q[SW-1:0];
						row_q       <= next_free_q[SW-1:0];
						cnt_q       <= '0;
						next_free_q <= next_free_q + NF_W'(1);
					end
				end
				ST_EP: begin
					pat_q   <= pat_q + (WW+1)'(1);
					ins_q   <= '0;
					built_q <= 1'b0;
				end
				ST_B_GCHK: begin
					t_q <= g_rd;
					f_q <= '0;
					x_q <= fs_q;
				end
				ST_WROOT: f_q <= g_rd;
				ST_WCHK:  if (g_rd != '0) f_q <= g_rd;
				ST_WFL:   x_q <= f_rd;
				ST_WDONE: if (txt_q) scan_q <= f_q;
				ST_B_MT:  mf_q <= m_rd;
				ST_B_MW:  tail_q <= tail_q + (SW+1)'(1);
				ST_B_NEXTC: c_q <= c_q + CW'(1);
				ST_B_POP: begin
					if (head_q == tail_q) begin
						built_q <= 1'b1;
						scan_q  <= '0;
						pos_q   <= '0;
						first_q <= 1'b0;
					end else begin
						head_q <= head_q + (SW+1)'(1);
					end
				end
				ST_B_PCHK: cur_q <= q_rd;
				ST_B_FS: begin
					fs_q <= f_rd;
					c_q  <= '0;
				end
				ST_T_MASK: begin
					mk_q <= m_rd;
					if (fmo_q && m_rd != '0) first_q <= 1'b1;
				end
				ST_T_EMIT: mk_q <= mk_rest;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Checks
	a_build_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind == KIND_BUILD |-> result.last && result.error_code == ERR_NONE)
		else $error("build result malformed");

	a_match_fields: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind == KIND_MATCH |-> result.state_count == '0
			&& result.error_code == ERR_NONE)
		else $error("match result carries build or error fields");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q >= NF_W'(1) && next_free_q <= NF_W'(MAX_STATES))
		else $error("state allocation out of range");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("match burst ended without final flag");

endmodule

// ===== dv/aho_corasick_byte_matcher_tb.sv =====
// Self-checking testbench for the Aho-Corasick byte matcher.
`timescale 1ns / 100ps

module aho_corasick_byte_matcher_tb;
	import acbm_pkg::*;

	// Predicts the result items of every accepted command item and checks them in order.
	class match_scoreboard;
		logic [6:0]  goto_row [MAX_STATES*ALPHABET];
		logic [6:0]  fail_to [MAX_STATES];
		logic [15:0] word_mask [MAX_STATES];
		int          free_state;
		int          word_count;
		int          trie_pos;
		int          scan_pos;
		logic [31:0] text_pos;
		bit          is_built;
		bit          first_seen;
		bit          first_only;
		result_t     pending [$];

		function new();
			foreach (goto_row[i]) goto_row[i] = '0;
			foreach (fail_to[i]) fail_to[i] = '0;
			foreach (word_mask[i]) word_mask[i] = '0;
			first_only = 0;
			clear_trie();
		endfunction

		function void clear_row(int s);
			for (int c = 0; c < ALPHABET; c++) goto_row[s*ALPHABET + c] = '0;
			fail_to[s] = '0;
			word_mask[s] = '0;
		endfunction

		function void clear_trie();
			clear_row(0);
			free_state = 1;
			word_count = 0;
			trie_pos = 0;
			scan_pos = 0;
			text_pos = '0;
			is_built = 0;
			first_seen = 0;
		endfunction

		// Follow failure links until an edge on c exists or the root is reached.
		function int advance(int s, int c);
			int hops;
			hops = 0;
			while (s != 0 && goto_row[s*ALPHABET + c] == 0 && hops < MAX_STATES) begin
				s = fail_to[s];
				hops++;
			end
			return goto_row[s*ALPHABET + c];
		endfunction

		// Breadth-first failure links with merged word masks.
		function void link_trie();
			int order [$];
			int s;
			int t;
			int f;
			fail_to[0] = '0;
			for (int c = 0; c < ALPHABET; c++) begin
				t = goto_row[c];
				if (t != 0 && order.size() < MAX_STATES) begin
					fail_to[t] = '0;
					word_mask[t] |= word_mask[0];
					order.push_back(t);
				end
			end
			for (int h = 0; h < order.size(); h++) begin
				s = order[h];
				for (int c = 0; c < ALPHABET; c++) begin
					t = goto_row[s*ALPHABET + c];
					if (t != 0 && order.size() < MAX_STATES) begin
						f = advance(fail_to[s], c);
						fail_to[t] = f[6:0];
						word_mask[t] |= word_mask[f];
						order.push_back(t);
					end
				end
			end
			is_built = 1;
			scan_pos = 0;
			text_pos = '0;
			first_seen = 0;
		endfunction

		function void add(kind_t k, int w, logic [31:0] p, int n, err_t e);
			result_t r;
			r.kind = k;
			r.word_index = w[3:0];
			r.end_position = p;
			r.state_count = n[7:0];
			r.error_code = e;
			r.last = 1'b0;
			pending.push_back(r);
		endfunction

		function void note(in_item_t it);
			int before_n;
			int c;
			int idx;
			logic [31:0] p;
			logic [15:0] m;
			before_n = pending.size();
			c = it.data_byte;
			if (it.command == CMD_CLEAR) begin
				clear_trie();
			end else if (it.command == CMD_PATTERN) begin
				if (word_count >= MAX_PATTERNS) begin
					add(KIND_ERROR, 0, '0, 0, ERR_PATTERNS);
				end else begin
					idx = trie_pos*ALPHABET + c;
					is_built = 0;
					if (goto_row[idx] == 0) begin
						if (free_state >= MAX_STATES) begin
							add(KIND_ERROR, 0, '0, 0, ERR_FULL);
						end else begin
							clear_row(free_state);
							goto_row[idx] = free_state[6:0];
							trie_pos = free_state;
							free_state++;
						end
					end else begin
						trie_pos = goto_row[idx];
					end
				end
			end else if (it.command == CMD_END) begin
				if (word_count >= MAX_PATTERNS) begin
					add(KIND_ERROR, 0, '0, 0, ERR_PATTERNS);
				end else begin
					word_mask[trie_pos][word_count] = 1'b1;
					word_count++;
					trie_pos = 0;
					is_built = 0;
				end
			end else if (it.command == CMD_BUILD) begin
				link_trie();
				add(KIND_BUILD, 0, '0, free_state, ERR_NONE);
			end else if (it.command == CMD_TEXT) begin
				if (!is_built) begin
					add(KIND_ERROR, 0, '0, 0, ERR_NOT_BUILT);
				end else begin
					if (it.start_of_text) begin
						scan_pos = 0;
						text_pos = '0;
						first_seen = 0;
					end
					p = text_pos;
					text_pos = text_pos + 1;
					scan_pos = advance(scan_pos, c);
					m = word_mask[scan_pos];
					if (first_only) begin
						if (!first_seen && m != 0) begin
							for (int w = 0; w < MAX_PATTERNS; w++) begin
								if (m[w]) begin
									add(KIND_MATCH, w, p, 0, ERR_NONE);
									break;
								end
							end
							first_seen = 1;
						end
					end else begin
						for (int w = 0; w < MAX_PATTERNS; w++)
							if (m[w]) add(KIND_MATCH, w, p, 0, ERR_NONE);
					end
				end
			end
			if (pending.size() > before_n) pending[pending.size()-1].last = 1'b1;
		endfunction

		// Return an empty string when the result matches the oldest prediction.
		function string check(result_t r);
			result_t e;
			if (pending.size() == 0) return $sformatf("unexpected result %p", r);
			e = pending.pop_front();
			if (r.kind !== e.kind || r.word_index !== e.word_index ||
					r.end_position !== e.end_position || r.state_count !== e.state_count ||
					r.error_code !== e.error_code || r.last !== e.last)
				return $sformatf("got %p, predicted %p", r, e);
			return "";
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	in_item_t item;
	logic     busy;
	logic     strobe;
	result_t  result;
	logic     cfg_valid;
	logic     cfg_ready;
	logic     cfg_data;

	match_scoreboard sb;
	int mismatches;
	int cycles;
	int sent;
	bit no_gaps;

	aho_corasick_byte_matcher i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.strobe(strobe), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	// Check every strobed result item.
	always @(posedge clk) begin
		string msg;
		if (arst_n && strobe) begin
			msg = sb.check(result);
			if (msg != "") report(msg);
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Present one item, with an optional random gap, and hold it until taken.
	task automatic send(input logic [2:0] cmd, input logic [7:0] data, input logic sot);
		in_item_t it;
		int gap;
		it.command = cmd;
		it.data_byte = data;
		it.start_of_text = sot;
		if (!no_gaps && $urandom_range(99) < 29) begin
			gap = $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		sb.note(it);
		if (cmd <= CMD_TEXT) sent++;
	endtask

	task automatic load_word(input logic [7:0] w [$]);
		foreach (w[i]) send(CMD_PATTERN, w[i], 1'b0);
		send(CMD_END, 8'($urandom), 1'b0);
	endtask

	// Drain all results and let any silent row clear finish.
	task automatic settle();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_mode(input logic v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.first_only = v;
	endtask

	initial begin
		logic [7:0] w [$];
		logic [7:0] sym [3];
		int n;
		int len;
		int ep;
		sb = new();
		mismatches = 0;
		cycles = 0;
		sent = 0;
		no_gaps = 0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_mode(1'b0);

		// Directed: text before build, empty build, extreme bytes, unused commands.
		send(CMD_TEXT, 8'h41, 1'b1);
		send(CMD_BUILD, 8'h00, 1'b0);
		load_word({8'h00, 8'hFF});
		load_word({8'hFF});
		send(CMD_BUILD, 8'hFF, 1'b1);
		send(CMD_TEXT, 8'h00, 1'b1);
		send(CMD_TEXT, 8'hFF, 1'b0);
		send(3'd5, 8'hAA, 1'b1);
		send(3'd7, 8'h55, 1'b0);
		send(CMD_TEXT, 8'hFF, 1'b0);
		set_mode(1'b1);
		send(CMD_TEXT, 8'hFF, 1'b0);
		send(CMD_TEXT, 8'hFF, 1'b1);
		send(CMD_TEXT, 8'hFF, 1'b0);
		set_mode(1'b0);

		// Directed: sixteen empty words fill the word limit and match everywhere.
		send(CMD_CLEAR, 8'h00, 1'b0);
		repeat (MAX_PATTERNS) send(CMD_END, 8'h00, 1'b0);
		send(CMD_END, 8'h00, 1'b0);
		send(CMD_PATTERN, 8'h12, 1'b0);
		send(CMD_BUILD, 8'h00, 1'b0);
		send(CMD_TEXT, 8'h80, 1'b1);

		// Random: episodes of well-formed loads and scans, with some noise.
		ep = 0;
		while (sent < 85) begin
			no_gaps = (ep == 1);
			if ($urandom_range(2) == 0) set_mode(1'($urandom_range(1)));
			for (int k = 0; k < 3; k++)
				sym[k] = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(97, 99));
			send(CMD_CLEAR, 8'($urandom), 1'($urandom));
			n = $urandom_range(1, 6);
			for (int p = 0; p < n; p++) begin
				w.delete();
				len = $urandom_range(1, 4);
				for (int b = 0; b < len; b++) w.push_back(sym[$urandom_range(2)]);
				load_word(w);
			end
			if ($urandom_range(4) != 0) send(CMD_BUILD, 8'($urandom), 1'($urandom));
			len = $urandom_range(8, 20);
			for (int b = 0; b < len; b++) begin
				if ($urandom_range(9) == 0)
					send(3'($urandom_range(7)), 8'($urandom), 1'($urandom));
				else
					send(CMD_TEXT, sym[$urandom_range(2)], ($urandom_range(9) == 0));
			end
			ep++;
		end
		no_gaps = 0;

		// Fill the state store with one long chain, then overflow it.
		send(CMD_CLEAR, 8'h00, 1'b0);
		for (int b = 0; b < MAX_STATES; b++) send(CMD_PATTERN, 8'(b), 1'b0);
		send(CMD_END, 8'h00, 1'b0);
		send(CMD_BUILD, 8'h00, 1'b0);
		for (int b = 0; b < 6; b++) send(CMD_TEXT, 8'(b), (b == 0));
		send(CMD_TEXT, 8'd126, 1'b0);

		settle();
		if (sb.pending.size() != 0) report("predicted results never arrived");
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
